>>> hdl/assert_macros.svh
// assertion helpers used by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge of clk_i, off while reset is held
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication form of the above
`define ASSERT_IMPL(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

`endif

>>> hdl/ile_pkg.sv
package ile_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = 5;
  localparam int POS_W      = 5;
  localparam int KIND_W     = 3;
  localparam int VAL_W      = 32;
  localparam int STATUS_W   = 2;
  localparam int MATCH_W    = 4;

  typedef logic [DATA_WIDTH-1:0] data_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [POS_W-1:0]      pos_t;

  typedef enum logic [KIND_W-1:0] {
    OP_INSERT = 3'd0,
    OP_REMOVE = 3'd1,
    OP_READ   = 3'd2,
    OP_WRITE  = 3'd3,
    OP_SEARCH = 3'd4
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_BAD_POS = 2'd1,
    ST_FULL    = 2'd2
  } status_e;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [POS_W-1:0]  position;
    logic [VAL_W-1:0]  item_value;
  } req_t;

  typedef struct packed {
    logic [VAL_W-1:0]    read_value;
    logic [MATCH_W-1:0]  match_position;
    logic                found;
    logic [STATUS_W-1:0] status;
    logic [CNT_W-1:0]    count;
  } res_t;

  // control broadcast to every cell of the row
  typedef struct packed {
    logic  shift_up;
    logic  shift_down;
    logic  wr_en;
    pos_t  pos;
    data_t val;
    cnt_t  count;
  } cell_ctl_t;

endpackage

>>> hdl/ile_cell.sv
module ile_cell (
  input  logic              clk_i,
  input  ile_pkg::cell_ctl_t ctl_i,
  input  ile_pkg::idx_t     idx_i,
  input  ile_pkg::data_t    left_i,
  input  ile_pkg::data_t    right_i,
  input  logic              any_i,
  output ile_pkg::data_t    data_o,
  output logic              any_o,
  output logic              first_o
);
  import ile_pkg::*;

  data_t data_q, data_d;
  pos_t  my_pos;
  logic  hit;

  assign my_pos = POS_W'(idx_i);

  // compare against the search key, only inside the live part of the list
  assign hit     = (CNT_W'(idx_i) < ctl_i.count) && (data_q == ctl_i.val);
  assign any_o   = any_i | hit;
  assign first_o = hit & ~any_i;
  assign data_o  = data_q;

  always_comb begin
    data_d = data_q;
    if (ctl_i.shift_up) begin
      if (my_pos > ctl_i.pos) begin
        data_d = left_i;
      end else if (my_pos == ctl_i.pos) begin
        data_d = ctl_i.val;
      end
    end else if (ctl_i.shift_down) begin
      if (my_pos >= ctl_i.pos) begin
        data_d = right_i;
      end
    end else if (ctl_i.wr_en) begin
      if (my_pos == ctl_i.pos) begin
        data_d = ctl_i.val;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

endmodule

>>> hdl/indexed_list_engine.sv
// indexed list engine: ordered list of up to DEPTH words held in a row of cells
//
// command channel: a beat (req_i) is taken at a rising edge where start is high
// and busy is low. busy stays low: every operation finishes in the cycle it is
// taken, so a new beat can follow on each clock.
// result channel: one result beat per command, on res_o with done_o high for
// exactly one cycle, the cycle right after the command was taken.
// the receiver cannot hold results off; it must take each beat when done_o is
// high. throughput is one command per cycle.
// every cell shifts, loads and compares its own entry in the same cycle, so the
// clock period is set by the ripple of the first-match chain across the row and the
// read mux on the position field.
// reset (rst_ni low, asynchronous) empties the list and drops done_o; entry
// contents are not cleared, positions at or above the count are never read.
// insert, remove, read, overwrite and search follow list semantics; a bad
// position or a full insert reports a status and leaves the list unchanged.
module indexed_list_engine (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  ile_pkg::req_t req_i,
  output logic          done_o,
  output ile_pkg::res_t res_o
);
  import ile_pkg::*;

  `include "assert_macros.svh"

  // list state
  cnt_t  count_q, count_d;
  logic  done_q;
  res_t  res_q, res_d;

  // row of cells
  cell_ctl_t       ctl;
  data_t           cell_data [DEPTH];
  logic [DEPTH:0]  any_chain;
  logic [DEPTH-1:0] first_hit;

  // request decode
  logic  accept;
  data_t key;
  logic  pos_in_list;   // position below the count
  logic  pos_insert_ok; // position at most the count
  logic  list_full;
  idx_t  match_idx;
  data_t rd_word;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign key    = req_i.item_value[DATA_WIDTH-1:0];

  assign pos_in_list   = CNT_W'(req_i.position) < count_q;
  assign pos_insert_ok = CNT_W'(req_i.position) <= count_q;
  assign list_full     = count_q >= CNT_W'(DEPTH);

  // shift and write enables fan out to all cells
  always_comb begin
    ctl            = '0;
    ctl.pos        = req_i.position;
    ctl.val        = key;
    ctl.count      = count_q;
    if (accept) begin
      case (req_i.kind)
        OP_INSERT: ctl.shift_up   = pos_insert_ok && !list_full;
        OP_REMOVE: ctl.shift_down = pos_in_list;
        OP_WRITE:  ctl.wr_en      = pos_in_list;
        default:   ctl.wr_en      = 1'b0;
      endcase
    end
  end

  assign any_chain[0] = 1'b0;

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      data_t left_w, right_w;
      if (g == 0) begin : g_first
        assign left_w = '0;
      end else begin : g_left
        assign left_w = cell_data[g-1];
      end
      if (g == DEPTH - 1) begin : g_last
        assign right_w = '0;
      end else begin : g_right
        assign right_w = cell_data[g+1];
      end

      ile_cell u_cell (
        .clk_i   (clk_i),
        .ctl_i   (ctl),
        .idx_i   (IDX_W'(g)),
        .left_i  (left_w),
        .right_i (right_w),
        .any_i   (any_chain[g]),
        .data_o  (cell_data[g]),
        .any_o   (any_chain[g+1]),
        .first_o (first_hit[g])
      );
    end
  endgenerate

  // first-match flag has at most one bit set, so an or of the indexes encodes it
  always_comb begin
    match_idx = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (first_hit[i]) begin
        match_idx = match_idx | IDX_W'(i);
      end
    end
  end

  // word at the requested position, only meaningful when it is in the list
  assign rd_word = cell_data[req_i.position[IDX_W-1:0]];

  // result and count for this beat
  always_comb begin
    res_d   = '0;
    count_d = count_q;
    case (req_i.kind)
      OP_INSERT: begin
        if (!pos_insert_ok) begin
          res_d.status = ST_BAD_POS;
        end else if (list_full) begin
          res_d.status = ST_FULL;
        end else begin
          count_d = count_q + CNT_W'(1);
        end
      end
      OP_REMOVE: begin
        if (!pos_in_list) begin
          res_d.status = ST_BAD_POS;
        end else begin
          res_d.read_value = VAL_W'(rd_word);
          count_d          = count_q - CNT_W'(1);
        end
      end
      OP_READ: begin
        if (!pos_in_list) begin
          res_d.status = ST_BAD_POS;
        end else begin
          res_d.read_value = VAL_W'(rd_word);
        end
      end
      OP_WRITE: begin
        if (!pos_in_list) begin
          res_d.status = ST_BAD_POS;
        end
      end
      OP_SEARCH: begin
        res_d.found          = any_chain[DEPTH];
        res_d.match_position = MATCH_W'(match_idx);
      end
      default: res_d.status = ST_OK;
    endcase
    res_d.count = count_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= accept;
      if (accept) begin
        count_q <= count_d;
      end
    end
  end

  // result payload needs no reset, done_o qualifies it
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  `ASSERT_CLK(a_count_cap, count_q <= CNT_W'(DEPTH), "entry count above capacity")
  `ASSERT_IMPL(a_done_follows, accept, ##1 done_o, "no result beat after command")
  `ASSERT_IMPL(a_insert_grows, ctl.shift_up, ##1 count_q == $past(count_q) + CNT_W'(1), "no growth")
  `ASSERT_IMPL(a_err_keeps_count, done_o && res_o.status != ST_OK, $stable(count_q), "count moved")

endmodule
